// ===== rtl/core/xorshift1024star_bounded_rng_defines.svh =====
// assertion macros for the xorshift1024* bounded generator checker
// no dependencies; included by the files that assert
`ifndef XORSHIFT1024STAR_BOUNDED_RNG_DEFINES_SVH
`define XORSHIFT1024STAR_BOUNDED_RNG_DEFINES_SVH

// next-cycle implication, muted while reset is asserted
`define XBR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("xbr: assertion failed");

// next-cycle implication that also holds across reset
`define XBR_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("xbr: assertion failed");

`endif

// ===== rtl/core/xbr_pkg.sv =====
// shared constants and types for the xorshift1024* bounded generator
// no dependencies; used by the interfaces, the arithmetic units and the top level
package xbr_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned WORD_COUNT  = 16;
  localparam int unsigned IDX_W       = $clog2(WORD_COUNT);
  localparam int unsigned REDRAW_LIMIT = 64;
  localparam int unsigned TRY_W       = $clog2(REDRAW_LIMIT + 1);
  localparam int unsigned MUL_DIGIT_W = 8;

  localparam logic [WORD_W-1:0] SCRAMBLE_MULT = 64'd1181783497276652981;
  localparam logic [WORD_W-1:0] SEED_RESET    = 64'd0;

  // xorshift shift amounts
  localparam int unsigned SHL_A = 31;
  localparam int unsigned SHR_B = 11;
  localparam int unsigned SHR_C = 30;

  // request operation codes
  localparam logic OP_RAW     = 1'b0;
  localparam logic OP_BOUNDED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ===== rtl/core/xbr_req_if.sv =====
// request channel: valid/ready handshake carrying operation and bound
// depends on xbr_pkg
interface xbr_req_if;
  import xbr_pkg::*;

  logic  valid;
  logic  ready;
  logic  operation;
  word_t bound;

  modport source (output valid, output operation, output bound, input ready);
  modport sink   (input valid, input operation, input bound, output ready);
endinterface

// ===== rtl/core/xbr_rsp_if.sv =====
// result channel: valid/ready handshake carrying value and error flag
// depends on xbr_pkg
interface xbr_rsp_if;
  import xbr_pkg::*;

  logic  valid;
  logic  ready;
  word_t value;
  logic  error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// ===== rtl/core/xorshift1024star_bounded_rng.sv =====
// xorshift1024* generator with raw and bounded (rejection + modulo) requests
// a raw draw reads two state words, runs the xorshift step and the scrambler multiply, then
//   registers the result; a bounded draw repeats this per drawn word (up to 64 words), then takes the remainder
// one request at a time: a new request is taken only once the result has entered the output register
// reset: synchronous active-low; all state words read as 1, word index 0, no result pending
// a seed write marks all state words as holding seed plus one
module xorshift1024star_bounded_rng #(
  parameter int unsigned DIGIT_W = xbr_pkg::MUL_DIGIT_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  xbr_req_if.sink                    in_ch,
  xbr_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [xbr_pkg::WORD_W-1:0] cfg_wdata
);
  import xbr_pkg::*;

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_CALC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_HOLD = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;

  // request registers
  logic                op_r;
  word_t               bound_r;
  logic [TRY_W-1:0]    tries_r, tries_nxt;

  // generator state: words live in a small ram; a valid bit per word tells
  // whether it was written since the last seed load, else it reads as seed plus one
  word_t               mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] wvalid_r;
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    idx_p1;
  word_t               seed_p1_r;
  word_t               rd0_r, rd1_r;
  logic                v0_r, v1_r;

  // xorshift step
  word_t               s0, s1, a_w, t_w;

  // pending result and output register
  word_t               res_value_r, res_value_nxt;
  logic                res_error_r, res_error_nxt;
  logic                out_valid_r;
  word_t               out_value_r;
  logic                out_error_r;

  // arithmetic units
  logic                mul_start, mul_done;
  word_t               mul_prod;
  logic                div_start, div_done;
  word_t               div_rem;

  logic                in_xfer;
  logic                out_load;
  logic                small_bound;
  logic                reject;
  logic [WORD_W:0]     sum_chk;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign small_bound = (in_ch.bound[WORD_W-1:1] == '0);
  assign idx_p1      = idx_r + 1'b1;

  // word is rejected when x > all-ones minus bound, i.e. x + bound carries out
  assign sum_chk = {1'b0, mul_prod} + {1'b0, bound_r};
  assign reject  = sum_chk[WORD_W];

  // s0 is the current word, s1 the next one
  assign s0  = v0_r ? rd0_r : seed_p1_r;
  assign s1  = v1_r ? rd1_r : seed_p1_r;
  assign a_w = s1 ^ (s1 << SHL_A);
  assign t_w = a_w ^ (a_w >> SHR_B) ^ s0 ^ (s0 >> SHR_C);

  assign mul_start = (state_r == S_CALC);
  assign div_start = (state_r == S_MUL) && mul_done && (op_r == OP_BOUNDED) &&
                     !(reject && (tries_r < TRY_W'(REDRAW_LIMIT)));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tries_nxt     = tries_r;
    res_value_nxt = res_value_r;
    res_error_nxt = res_error_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          tries_nxt = '0;
          if ((in_ch.operation == OP_BOUNDED) && small_bound) begin
            // bound below two: flag it, leave the state alone
            res_value_nxt = '0;
            res_error_nxt = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            res_error_nxt = 1'b0;
            state_nxt     = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        tries_nxt = tries_r + 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          if (op_r == OP_RAW) begin
            res_value_nxt = mul_prod;
            state_nxt     = S_DONE;
          end else if (reject && (tries_r < TRY_W'(REDRAW_LIMIT))) begin
            state_nxt = S_READ;   // redraw
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_value_nxt = div_rem;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_ch.ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tries_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      wvalid_r    <= '0;
      seed_p1_r   <= SEED_RESET + 1'b1;
    end else begin
      state_r <= state_nxt;
      tries_r <= tries_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        // seed load: every word now reads as seed plus one
        seed_p1_r <= cfg_wdata + 1'b1;
        wvalid_r  <= '0;
        idx_r     <= '0;
      end else if (state_r == S_CALC) begin
        wvalid_r[idx_p1] <= 1'b1;
        idx_r            <= idx_p1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_error_r <= res_error_nxt;
    if (in_xfer) begin
      op_r    <= in_ch.operation;
      bound_r <= in_ch.bound;
    end
    if (out_load) begin
      out_value_r <= res_value_r;
      out_error_r <= res_error_r;
    end
  end

  // state word ram: two registered reads, one write
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd0_r <= mem[idx_r];
      rd1_r <= mem[idx_p1];
      v0_r  <= wvalid_r[idx_r];
      v1_r  <= wvalid_r[idx_p1];
    end
    if (state_r == S_CALC) begin
      mem[idx_p1] <= t_w;
    end
  end

  // scrambler multiply, one digit per cycle
  xbr_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (t_w),
    .done    (mul_done),
    .product (mul_prod)
  );

  // remainder by the bound, one bit per cycle
  xbr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mul_prod),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_ch.error = out_error_r;

endmodule

// ===== rtl/core/xbr_mul.sv =====
// digit-serial multiply of a 64-bit word by the scrambler constant, modulo 2^64
// depends on xbr_pkg
module xbr_mul #(
  parameter int unsigned DIGIT_W = xbr_pkg::MUL_DIGIT_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [xbr_pkg::WORD_W-1:0] operand,
  output logic                      done,
  output logic [xbr_pkg::WORD_W-1:0] product
);
  import xbr_pkg::*;

  localparam int unsigned STEPS = WORD_W / DIGIT_W;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned PP_W  = WORD_W + DIGIT_W;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  word_t             opnd_r;
  word_t             mult_r;
  word_t             acc_r;
  logic [PP_W-1:0]   pp;
  word_t             acc_nxt;

  // one partial product per cycle: constant times the low digit
  assign pp      = PP_W'(mult_r) * PP_W'(opnd_r[DIGIT_W-1:0]);
  assign acc_nxt = acc_r + pp[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd_r <= operand;
      mult_r <= SCRAMBLE_MULT;
      acc_r  <= '0;
    end else if (busy_r) begin
      opnd_r <= opnd_r >> DIGIT_W;
      mult_r <= mult_r << DIGIT_W;
      acc_r  <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/core/xbr_div.sv =====
// bit-serial restoring remainder of a 64-bit word by a 64-bit divisor
// depends on xbr_pkg
module xbr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [xbr_pkg::WORD_W-1:0] dividend,
  input  logic [xbr_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [xbr_pkg::WORD_W-1:0] remainder
);
  import xbr_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W:0]   rem_r;
  word_t             dvd_r;
  word_t             dvs_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W:0]   rem_nxt;

  // bring in the next dividend bit, subtract when it fits
  assign shifted = {rem_r[WORD_W-1:0], dvd_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign rem_nxt = diff[WORD_W] ? shifted : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[WORD_W-1:0];

endmodule

// ===== rtl/core/xbr_chk.sv =====
// port-level checks for the xorshift1024* bounded generator, bound to the top level
// depends on xorshift1024star_bounded_rng_defines.svh and xbr_pkg
`include "xorshift1024star_bounded_rng_defines.svh"

module xbr_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [xbr_pkg::WORD_W-1:0] out_value,
  input logic                       out_error
);
  import xbr_pkg::*;

  // one request at a time: no second transfer right after one
  `XBR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

  // reset empties the output register
  `XBR_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // a stalled result holds
  `XBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_error))

  // an error result carries zero, checked after an output transfer with no request transfer in the same cycle
  `XBR_ASSERT_NEXT(a_err_zero, clk, rst_n, out_valid && out_ready && !(in_valid && in_ready), !(out_valid && out_error && (out_value != '0)))

endmodule

bind xorshift1024star_bounded_rng xbr_chk u_xbr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .out_error (out_ch.error)
);
